// File: src/tgcl_pkg.sv
// Shared types, codes and constants of the tiled collage layout generator.
package tgcl_pkg;

  localparam int KIND_W     = 2;
  localparam int TILE_W     = 6;
  localparam int DIM_W      = 12;
  localparam int CLS_W      = 2;
  localparam int SRC_W      = 11;
  localparam int GRD_W      = 4;
  localparam int BRD_W      = 8;
  localparam int OFF_W      = 12;
  localparam int RGN_W      = 2;
  localparam int TIDX_W     = 8;
  localparam int ENTRY_W    = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Saturation limits of tile sizes and border widths.
  localparam int TILE_DIM_MAX = 2048;
  localparam int BORDER_MAX   = 255;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Pixel classes.
  localparam logic [CLS_W-1:0] CLS_BORDER     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_BACKGROUND = 2'd1;
  localparam logic [CLS_W-1:0] CLS_IMAGE      = 2'd2;
  localparam logic [CLS_W-1:0] CLS_EMPTY      = 2'd3;

  // Axis regions.
  localparam logic [RGN_W-1:0] RGN_LEAD  = 2'd0;
  localparam logic [RGN_W-1:0] RGN_BAND  = 2'd1;
  localparam logic [RGN_W-1:0] RGN_CELL  = 2'd2;
  localparam logic [RGN_W-1:0] RGN_TRAIL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_BORDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_BORDER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BLOCK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_BLOCK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_CELLS = 3'd6;

  // Position along one axis.
  typedef struct packed {
    logic [RGN_W-1:0] region;
    logic [GRD_W-1:0] tile;
    logic [OFF_W-1:0] offset;
    logic [GRD_W-1:0] bcount;
  } axis_pos_t;

  // Layout of one axis.
  typedef struct packed {
    logic [GRD_W-1:0] n;
    logic [DIM_W-1:0] cell_dim;
    logic [BRD_W-1:0] outer;
    logic [BRD_W-1:0] band;
    logic [GRD_W-1:0] block;
  } axis_lay_t;

  // Tile size write request.
  typedef struct packed {
    logic              en;
    logic [TILE_W-1:0] index;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  width;
  } tbl_wr_t;

endpackage

// File: src/tgcl_if.sv
// Channel interfaces: pixel requests, pixel results and configuration writes.
interface tgcl_req_if
  import tgcl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TILE_W-1:0] tile_index;
  logic [DIM_W-1:0]  tile_height;
  logic [DIM_W-1:0]  tile_width;

  modport source(output valid, kind, tile_index, tile_height, tile_width, input ready);
  modport sink(input valid, kind, tile_index, tile_height, tile_width, output ready);
endinterface

interface tgcl_rsp_if
  import tgcl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CLS_W-1:0]  pixel_class;
  logic [TILE_W-1:0] source_tile;
  logic [SRC_W-1:0]  source_row;
  logic [SRC_W-1:0]  source_col;
  logic              end_of_line;
  logic              end_of_frame;

  modport source(output valid, pixel_class, source_tile, source_row, source_col,
                 end_of_line, end_of_frame, input ready);
  modport sink(input valid, pixel_class, source_tile, source_row, source_col,
               end_of_line, end_of_frame, output ready);
endinterface

interface tgcl_cfg_if
  import tgcl_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/tile_grid_collage_layout.sv
// Tiled collage layout generator: top level with request and result pipeline.
//
// Channels: req_i carries requests of three kinds. A size write stores one
// tile's height and width and raises the running maxima; a clear empties the
// table, the maxima and the raster position; a pixel request walks the collage
// one pixel in raster order and yields exactly one result on rsp_o. Other
// kinds are taken and dropped. cfg_i writes the layout registers (grid size,
// frame and band widths, block sizes, square cells); it is always ready and
// is meant to be written while no pixel request is in flight.
// Pipeline: when a pixel request is taken, the position update happens and
// the table read data and the request's position are registered; the pixel
// class is formed from them and registered into rsp_o when that stage is free.
// Throughput: one request per cycle while rsp_o is not held, set by the
// position update and the one-read-per-cycle tile table.
// Reset: the table reads as empty, maxima are zero, the position sits at the
// top-left frame corner and the registers take their default values.
// Stall: a held result keeps its output register; one more pixel request is taken
// into the middle stage, then req_i.ready drops until rsp_o.ready returns.
module tile_grid_collage_layout
  import tgcl_pkg::*;
#(
  parameter int GRID_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgcl_cfg_if.sink    cfg_i,
  tgcl_req_if.sink    req_i,
  tgcl_rsp_if.source  rsp_o
);

  localparam int TileCount = GRID_MAX * GRID_MAX;
  localparam int TileAw    = (TileCount > 1) ? $clog2(TileCount) : 1;

  typedef struct packed {
    logic              in_cell;
    logic              empty;
    logic [TIDX_W-1:0] tile;
    logic [OFF_W-1:0]  row_off;
    logic [OFF_W-1:0]  col_off;
    logic              eol;
    logic              eof;
  } meta_t;

  logic              fire, is_write, is_clear, is_pixel, empty, step;
  logic              a_valid_q, a_valid_d, b_ready, a_move;
  logic              rsp_valid_q, rsp_valid_d;
  meta_t             meta_q, meta_d;
  tbl_wr_t           wr;
  axis_lay_t         row_lay, col_lay;
  axis_pos_t         row_pos, col_pos;
  logic              row_wrap, col_wrap;
  logic [TIDX_W-1:0] tidx;
  logic [DIM_W-1:0]  rd_h, rd_w, max_h, max_w;

  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [TILE_W-1:0] stile_q, stile_d;
  logic [SRC_W-1:0]  srow_q, srow_d, scol_q, scol_d;
  logic              eol_q, eof_q;

  assign b_ready     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !a_valid_q || b_ready;
  assign fire        = req_i.valid && req_i.ready;
  assign is_write    = fire && (req_i.kind == KIND_WRITE);
  assign is_clear    = fire && (req_i.kind == KIND_CLEAR);
  assign is_pixel    = fire && (req_i.kind == KIND_PIXEL);
  assign empty       = (max_h == '0) || (max_w == '0);
  assign step        = is_pixel && !empty;
  assign a_move      = a_valid_q && b_ready;

  assign wr = '{en: is_write, index: req_i.tile_index,
                height: req_i.tile_height, width: req_i.tile_width};

  tgcl_cfg #(
    .GRID_MAX(GRID_MAX)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .max_h_i  (max_h),
    .max_w_i  (max_w),
    .row_lay_o(row_lay),
    .col_lay_o(col_lay)
  );

  tgcl_axis u_col (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .lay_i (col_lay),
    .clr_i (is_clear),
    .step_i(step),
    .bump_i(1'b1),
    .pos_o (col_pos),
    .wrap_o(col_wrap)
  );

  // The row advances only when the column wraps.
  tgcl_axis u_row (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .lay_i (row_lay),
    .clr_i (is_clear),
    .step_i(step),
    .bump_i(col_wrap),
    .pos_o (row_pos),
    .wrap_o(row_wrap)
  );

  assign tidx = TIDX_W'(TIDX_W'(row_pos.tile) * TIDX_W'(col_lay.n)) + TIDX_W'(col_pos.tile);

  tgcl_table #(
    .TILE_COUNT(TileCount)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .clr_i    (is_clear),
    .rd_i     (is_pixel),
    .rd_addr_i(TileAw'(tidx)),
    .rd_h_o   (rd_h),
    .rd_w_o   (rd_w),
    .max_h_o  (max_h),
    .max_w_o  (max_w)
  );

  always_comb begin
    meta_d.in_cell = !empty && (row_pos.region == RGN_CELL) && (col_pos.region == RGN_CELL);
    meta_d.empty   = empty;
    meta_d.tile    = tidx;
    meta_d.row_off = row_pos.offset;
    meta_d.col_off = col_pos.offset;
    meta_d.eol     = col_wrap;
    meta_d.eof     = row_wrap;
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (is_pixel) a_valid_d = 1'b1;
    else if (a_move) a_valid_d = 1'b0;
    rsp_valid_d = rsp_valid_q;
    if (a_move) rsp_valid_d = 1'b1;
    else if (rsp_o.ready) rsp_valid_d = 1'b0;
  end

  // Classify against the tile's own size read from the table.
  always_comb begin
    cls_d   = CLS_BORDER;
    stile_d = '0;
    srow_d  = '0;
    scol_d  = '0;
    if (meta_q.empty) begin
      cls_d = CLS_EMPTY;
    end else if (meta_q.in_cell) begin
      if (meta_q.row_off < rd_h && meta_q.col_off < rd_w) begin
        cls_d   = CLS_IMAGE;
        stile_d = meta_q.tile[TILE_W-1:0];
        srow_d  = meta_q.row_off[SRC_W-1:0];
        scol_d  = meta_q.col_off[SRC_W-1:0];
      end else begin
        cls_d = CLS_BACKGROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pixel) begin
      meta_q <= meta_d;
    end
    if (a_move) begin
      cls_q   <= cls_d;
      stile_q <= stile_d;
      srow_q  <= srow_d;
      scol_q  <= scol_d;
      eol_q   <= meta_q.eol;
      eof_q   <= meta_q.eof;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.pixel_class  = cls_q;
  assign rsp_o.source_tile  = stile_q;
  assign rsp_o.source_row   = srow_q;
  assign rsp_o.source_col   = scol_q;
  assign rsp_o.end_of_line  = eol_q;
  assign rsp_o.end_of_frame = eof_q;

endmodule

// File: src/tgcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tgcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tgcl_table.sv
// Tile size table with per-entry valid bits and running size maxima.
module tgcl_table
  import tgcl_pkg::*;
#(
  parameter int TILE_COUNT = 64,
  localparam int AW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_wr_t          wr_i,
  input  logic             clr_i,
  input  logic             rd_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [DIM_W-1:0] rd_h_o,
  output logic [DIM_W-1:0] rd_w_o,
  output logic [DIM_W-1:0] max_h_o,
  output logic [DIM_W-1:0] max_w_o
);

  logic [TILE_COUNT-1:0] valid_q, valid_d;
  logic                  rd_valid_q;
  logic [DIM_W-1:0]      max_h_q, max_h_d;
  logic [DIM_W-1:0]      max_w_q, max_w_d;
  logic [DIM_W-1:0]      h_sat, w_sat;
  logic                  wr_hit;
  logic [AW-1:0]         wr_addr;
  logic [ENTRY_W-1:0]    rdata;

  assign h_sat   = (32'(wr_i.height) > TILE_DIM_MAX) ? DIM_W'(TILE_DIM_MAX) : wr_i.height;
  assign w_sat   = (32'(wr_i.width) > TILE_DIM_MAX) ? DIM_W'(TILE_DIM_MAX) : wr_i.width;
  assign wr_hit  = wr_i.en && (32'(wr_i.index) < TILE_COUNT);
  assign wr_addr = AW'(wr_i.index);

  always_comb begin
    valid_d = valid_q;
    max_h_d = max_h_q;
    max_w_d = max_w_q;
    if (clr_i) begin
      valid_d = '0;
      max_h_d = '0;
      max_w_d = '0;
    end else if (wr_i.en) begin
      if (wr_hit) begin
        valid_d[wr_addr] = 1'b1;
      end
      // Tiles of zero height leave the maxima alone.
      if (h_sat != '0) begin
        if (h_sat > max_h_q) max_h_d = h_sat;
        if (w_sat > max_w_q) max_w_d = w_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      max_h_q    <= '0;
      max_w_q    <= '0;
    end else begin
      valid_q <= valid_d;
      max_h_q <= max_h_d;
      max_w_q <= max_w_d;
      if (rd_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  tgcl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TILE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_hit),
    .waddr_i(wr_addr),
    .wdata_i({h_sat, w_sat}),
    .re_i   (rd_i),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  // An entry never written since the last clear reads as an empty tile.
  assign rd_h_o  = rd_valid_q ? rdata[ENTRY_W-1:DIM_W] : '0;
  assign rd_w_o  = rd_valid_q ? rdata[DIM_W-1:0] : '0;
  assign max_h_o = max_h_q;
  assign max_w_o = max_w_q;

endmodule

// File: src/tgcl_cfg.sv
// Configuration registers and the per-axis layout derived from them.
module tgcl_cfg
  import tgcl_pkg::*;
#(
  parameter int GRID_MAX = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tgcl_cfg_if.sink         cfg_i,
  input  logic [DIM_W-1:0] max_h_i,
  input  logic [DIM_W-1:0] max_w_i,
  output axis_lay_t        row_lay_o,
  output axis_lay_t        col_lay_o
);

  logic [GRD_W-1:0] grid_rows_q, grid_cols_q, row_block_q, col_block_q;
  logic [BRD_W-1:0] outer_q, division_q;
  logic             square_q;
  logic [GRD_W-1:0] nr, nc;
  logic [BRD_W-1:0] ob, db;
  logic [DIM_W-1:0] ch, cw, cmax;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRD_W'(1);
      grid_cols_q <= GRD_W'(1);
      outer_q     <= BRD_W'(5);
      division_q  <= BRD_W'(5);
      row_block_q <= GRD_W'(1);
      col_block_q <= GRD_W'(1);
      square_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_GRID_ROWS:    grid_rows_q <= cfg_i.data[GRD_W-1:0];
        CFG_GRID_COLS:    grid_cols_q <= cfg_i.data[GRD_W-1:0];
        CFG_OUTER_BORDER: outer_q     <= cfg_i.data[BRD_W-1:0];
        CFG_DIV_BORDER:   division_q  <= cfg_i.data[BRD_W-1:0];
        CFG_ROW_BLOCK:    row_block_q <= cfg_i.data[GRD_W-1:0];
        CFG_COL_BLOCK:    col_block_q <= cfg_i.data[GRD_W-1:0];
        CFG_SQUARE_CELLS: square_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [GRD_W-1:0] clamp_grid(logic [GRD_W-1:0] v);
    logic [GRD_W-1:0] r;
    r = v;
    if (v == '0) r = GRD_W'(1);
    else if (32'(v) > GRID_MAX) r = GRD_W'(GRID_MAX);
    return r;
  endfunction

  function automatic logic [GRD_W-1:0] block_of(logic [GRD_W-1:0] arg, logic [GRD_W-1:0] n,
                                               logic [BRD_W-1:0] band);
    logic [GRD_W-1:0] r;
    r = arg;
    if (band == '0) r = GRD_W'(1);
    else if (arg == '0 || arg > n) r = n;
    return r;
  endfunction

  assign nr   = clamp_grid(grid_rows_q);
  assign nc   = clamp_grid(grid_cols_q);
  assign ob   = (32'(outer_q) > BORDER_MAX) ? BRD_W'(BORDER_MAX) : outer_q;
  assign db   = (32'(division_q) > BORDER_MAX) ? BRD_W'(BORDER_MAX) : division_q;
  assign cmax = (max_h_i > max_w_i) ? max_h_i : max_w_i;
  assign ch   = square_q ? cmax : max_h_i;
  assign cw   = square_q ? cmax : max_w_i;

  assign row_lay_o = '{n: nr, cell_dim: ch, outer: ob, band: db,
                       block: block_of(row_block_q, nr, db)};
  assign col_lay_o = '{n: nc, cell_dim: cw, outer: ob, band: db,
                       block: block_of(col_block_q, nc, db)};

endmodule

// File: src/tgcl_axis.sv
// Raster position along one axis: settles past spent regions and advances.
module tgcl_axis
  import tgcl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  axis_lay_t lay_i,
  input  logic      clr_i,
  input  logic      step_i,
  input  logic      bump_i,
  output axis_pos_t pos_o,
  output logic      wrap_o
);

  typedef struct packed {
    axis_pos_t pos;
    logic      wrapped;
  } settle_t;

  localparam axis_pos_t PosLead = '{RGN_LEAD, '0, '0, '0};
  localparam axis_pos_t PosCell = '{RGN_CELL, '0, '0, '0};

  axis_pos_t pos_q, pos_d, inc;
  settle_t   pre, post;

  // Closed form of walking forward over empty or exhausted regions.
  function automatic settle_t settle(axis_pos_t p, axis_lay_t l);
    settle_t        r;
    logic [GRD_W:0] t1;
    logic [GRD_W:0] b1;
    t1        = {1'b0, p.tile} + (GRD_W+1)'(1);
    b1        = {1'b0, p.bcount} + (GRD_W+1)'(1);
    r.pos     = p;
    r.wrapped = 1'b0;
    unique case (p.region)
      RGN_LEAD: begin
        if (p.offset >= OFF_W'(l.outer)) r.pos = PosCell;
      end
      RGN_BAND: begin
        if (p.offset >= OFF_W'(l.band)) begin
          if (p.tile < l.n) begin
            r.pos = '{RGN_CELL, p.tile, '0, '0};
          end else if (l.outer != '0) begin
            r.pos = '{RGN_TRAIL, p.tile, '0, '0};
          end else begin
            r.pos     = PosCell;
            r.wrapped = 1'b1;
          end
        end
      end
      RGN_CELL: begin
        if (p.tile >= l.n) begin
          if (l.outer != '0) begin
            r.pos = '{RGN_TRAIL, p.tile, '0, p.bcount};
          end else begin
            r.pos     = PosCell;
            r.wrapped = 1'b1;
          end
        end else if (p.offset >= l.cell_dim) begin
          if (t1 >= {1'b0, l.n}) begin
            if (l.outer != '0) begin
              r.pos = '{RGN_TRAIL, t1[GRD_W-1:0], '0, b1[GRD_W-1:0]};
            end else begin
              r.pos     = PosCell;
              r.wrapped = 1'b1;
            end
          end else if (l.band != '0 && b1 >= {1'b0, l.block}) begin
            r.pos = '{RGN_BAND, t1[GRD_W-1:0], '0, b1[GRD_W-1:0]};
          end else begin
            r.pos = '{RGN_CELL, t1[GRD_W-1:0], '0, b1[GRD_W-1:0]};
          end
        end
      end
      RGN_TRAIL: begin
        if (p.offset >= OFF_W'(l.outer)) begin
          r.wrapped = 1'b1;
          r.pos     = (l.outer != '0) ? PosLead : PosCell;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    pre        = settle(pos_q, lay_i);
    inc        = pre.pos;
    inc.offset = pre.pos.offset + OFF_W'(1);
    post       = settle(inc, lay_i);
  end

  always_comb begin
    pos_d = pos_q;
    if (clr_i) begin
      pos_d = PosLead;
    end else if (step_i) begin
      pos_d = bump_i ? post.pos : pre.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosLead;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o  = pre.pos;
  assign wrap_o = step_i && bump_i && post.wrapped;

endmodule
